FILE: rtl/poisson_passage_term_scorer_defines.svh
// Assertion macros for the poisson passage term scorer.
`ifndef POISSON_PASSAGE_TERM_SCORER_DEFINES_SVH
`define POISSON_PASSAGE_TERM_SCORER_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define PPTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppts: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define PPTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppts: next-cycle check failed");
`else
`define PPTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PPTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ppts_pkg.sv
// Shared types and constants of the poisson passage term scorer.
`default_nettype none
package ppts_pkg;

    localparam int CFG_W   = 48;
    localparam int N_W     = 48;
    localparam int SCORE_W = 40;
    localparam int PROD_W  = 78;
    localparam int IP_W    = 62;
    localparam int LOG_BITS = 24;

    localparam logic [15:0] MU_RESET = 16'd2500;
    localparam logic [N_W-1:0] N_RESET = 48'd1;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_SMOOTHING_MU    = 1'b0;
    localparam cfg_index_t CFG_COLLECTION_SIZE = 1'b1;

    typedef struct packed {
        logic [15:0] passage_term_freq;
        logic [39:0] coll_term_freq;
        logic [15:0] passage_length;
        logic        last_term;
    } term_word_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] passage_score;
        logic                      domain_error;
    } score_word_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_FILL_START,
        OP_FILL_LOAD,
        OP_FILL_STORE,
        OP_CAPTURE,
        OP_MUL1,
        OP_MUL2,
        OP_MSUM,
        OP_DIV1,
        OP_IP,
        OP_DIV2,
        OP_LAMBDA,
        OP_LN_NORM,
        OP_LN_SQINIT,
        OP_LN_SQ,
        OP_LN_MAG,
        OP_LN_MUL,
        OP_LN_RND,
        OP_TMUL,
        OP_TSUB1,
        OP_TSUB2,
        OP_ACC
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic norm_done;
        logic sq_last;
        logic lam_zero;
        logic fill_last;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/ppts_div.sv
// Restoring radix-2 divider shared by both per-term divisions.
`default_nettype none
module ppts_div
    import ppts_pkg::*;
#(
    parameter int DW = 78
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [N_W-1:0] divisor,
    output logic               busy,
    output logic [DW-1:0]      quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]  dvd_reg;
    logic [N_W-1:0] rem_reg;
    logic [N_W-1:0] dvs_reg;
    logic [CW-1:0]  cnt_reg;
    logic [N_W:0]   trial;
    logic [N_W:0]   diff;
    logic           fits;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign busy  = cnt_reg != '0;
    assign quotient = dvd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(DW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy)
        begin
            rem_reg <= fits ? diff[N_W-1:0] : trial[N_W-1:0];
            dvd_reg <= {dvd_reg[DW-2:0], fits};
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ppts_datapath.sv
// Datapath: term arithmetic, log unit, log-factorial memory and score accumulator.
`default_nettype none
module ppts_datapath
    import ppts_pkg::*;
#(
    parameter int MAX_TERM_FREQ = 1023,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dp_cmd_t          cmd,
    output dp_status_t            status,
    input  wire term_word_t       term_word,
    output score_word_t           score_word,
    output logic                  score_valid,
    input  wire logic             score_stall,
    input  wire logic             cfg_wr_en,
    input  wire cfg_index_t       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int IW   = $clog2(MAX_TERM_FREQ + 1);
    localparam int LF_W = IW + 5 + FRAC_BITS;
    localparam int RW   = FRAC_BITS + 7;
    localparam int TPW  = 16 + RW;
    localparam int DIVW = (56 + FRAC_BITS > PROD_W) ? 56 + FRAC_BITS : PROD_W;
    localparam logic signed [63:0] S40_MAX = 64'sd549755813887;
    localparam logic signed [63:0] S40_MIN = -64'sd549755813888;

    function automatic logic signed [SCORE_W-1:0] sat40(input logic signed [63:0] v);
        logic signed [SCORE_W-1:0] r;
        if (v > S40_MAX)
            r = S40_MAX[SCORE_W-1:0];
        else if (v < S40_MIN)
            r = S40_MIN[SCORE_W-1:0];
        else
            r = v[SCORE_W-1:0];
        return r;
    endfunction

    logic [15:0]     mu_reg;
    logic [N_W-1:0]  n_reg;
    logic [15:0]     f_reg;
    logic [39:0]     g_reg;
    logic [15:0]     len_reg;
    logic            last_reg;
    logic [LF_W-1:0] lf_rd_reg;
    logic [47:0]     pl_reg;
    logic [45:0]     ph_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [IP_W-1:0] ip_reg;
    logic [IP_W-1:0] lambda_reg;
    logic [63:0]     x_reg;
    logic [5:0]      p_reg;
    logic [30:0]     m_reg;
    logic [LOG_BITS-1:0] fb_reg;
    logic [4:0]      cnt_reg;
    logic            neg_reg;
    logic [30:0]     mag_reg;
    logic [62:0]     lprod_reg;
    logic [RW-1:0]   res_reg;
    logic [TPW-1:0]  tp_reg;
    logic signed [63:0] t1_reg;
    logic signed [SCORE_W-1:0] term_reg;
    logic            term_err_reg;
    logic [IW-1:0]   k_reg;
    logic [LF_W-1:0] lf_acc_reg;
    logic signed [SCORE_W-1:0] accum_reg;
    logic            err_reg;
    logic            score_valid_reg;
    score_word_t     score_word_reg;

    logic [LF_W-1:0] lf_mem [0:MAX_TERM_FREQ];

    logic [31:0]     mul_a_lo;
    logic [29:0]     mul_a_hi;
    logic [15:0]     mul_b;
    logic            div_start;
    logic [DIVW-1:0] div_dividend;
    logic [N_W-1:0]  div_divisor;
    logic            div_busy;
    logic [DIVW-1:0] div_quot;
    logic [N_W-1:0]  n_eff;
    logic [16:0]     dsum;
    logic [62:0]     ip_sum;
    logic            ip_over;
    logic [IP_W-1:0] lam_val;
    logic [31:0]     sq_top;
    logic signed [7:0]  p_exp;
    logic signed [31:0] y_val;
    logic [62:0]     rnd_val;
    logic [15:0]     fm;
    logic signed [63:0] tp_ext;
    logic signed [63:0] t2_val;
    logic signed [SCORE_W-1:0] acc_sum;
    logic [LF_W-1:0] lf_sum;
    logic            lf_we;
    logic [IW-1:0]   lf_waddr;
    logic [LF_W-1:0] lf_wdata;
    logic [IW-1:0]   rd_addr;
    logic            lam_zero;

    // shared partial-product operands
    always_comb
    begin
        if (cmd.op == OP_MUL2)
        begin
            mul_a_lo = ip_reg[31:0];
            mul_a_hi = ip_reg[61:32];
            mul_b    = len_reg;
        end
        else
        begin
            mul_a_lo = g_reg[31:0];
            mul_a_hi = {22'd0, g_reg[39:32]};
            mul_b    = mu_reg;
        end
    end

    assign n_eff = (n_reg == '0) ? N_RESET : n_reg;
    assign dsum  = {1'b0, len_reg} + {1'b0, mu_reg};
    assign div_start = (cmd.op == OP_DIV1) || (cmd.op == OP_DIV2);
    assign div_dividend = (cmd.op == OP_DIV1) ?
                          DIVW'({prod_reg[55:0], {FRAC_BITS{1'b0}}}) : DIVW'(prod_reg);
    assign div_divisor  = (cmd.op == OP_DIV1) ? n_eff : N_W'(dsum);

    ppts_div #(
        .DW (DIVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign ip_over = |div_quot[DIVW-1:IP_W];
    assign ip_sum  = (63'(f_reg) << FRAC_BITS) + {1'b0, div_quot[IP_W-1:0]};
    // zero divisor only when length and mu are both zero: rate is zero
    assign lam_val = (len_reg == '0 && mu_reg == '0) ? '0 : div_quot[IP_W-1:0];
    assign lam_zero = lambda_reg == '0;

    assign sq_top  = 32'(({31'd0, m_reg} * {31'd0, m_reg}) >> 30);
    assign p_exp   = $signed({2'b00, p_reg}) - $signed(8'(FRAC_BITS));
    assign y_val   = $signed({p_exp, 24'd0}) + $signed({8'd0, fb_reg});
    assign rnd_val = lprod_reg + (63'(1) << (55 - FRAC_BITS));
    assign fm      = (f_reg == '0) ? 16'd1 : f_reg;
    assign tp_ext  = $signed(64'(tp_reg));
    assign t2_val  = t1_reg - $signed(64'(lambda_reg));
    assign acc_sum = sat40(64'(accum_reg) + 64'(term_reg));
    assign lf_sum  = lf_acc_reg + LF_W'(res_reg);

    assign rd_addr = (term_word.passage_term_freq > 16'(MAX_TERM_FREQ)) ?
                     IW'(MAX_TERM_FREQ) : IW'(term_word.passage_term_freq);

    always_comb
    begin
        lf_we    = 1'b0;
        lf_waddr = k_reg;
        lf_wdata = lf_sum;
        if (cmd.op == OP_FILL_START)
        begin
            lf_we    = 1'b1;
            lf_waddr = '0;
            lf_wdata = '0;
        end
        else if (cmd.op == OP_FILL_STORE)
        begin
            lf_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lf_we)
        begin
            lf_mem[lf_waddr] <= lf_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CAPTURE)
        begin
            lf_rd_reg <= lf_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_FILL_START:
            begin
                k_reg      <= IW'(1);
                lf_acc_reg <= '0;
            end
            OP_FILL_LOAD:
            begin
                x_reg <= 64'(k_reg) << FRAC_BITS;
                p_reg <= 6'd63;
            end
            OP_FILL_STORE:
            begin
                lf_acc_reg <= lf_sum;
                k_reg      <= k_reg + IW'(1);
            end
            OP_CAPTURE:
            begin
                f_reg    <= term_word.passage_term_freq;
                g_reg    <= (term_word.passage_term_freq == '0 &&
                             term_word.coll_term_freq == '0) ? 40'd1 :
                            term_word.coll_term_freq;
                len_reg  <= term_word.passage_length;
                last_reg <= term_word.last_term;
            end
            OP_MUL1, OP_MUL2:
            begin
                pl_reg <= {16'd0, mul_a_lo} * {32'd0, mul_b};
                ph_reg <= {16'd0, mul_a_hi} * {30'd0, mul_b};
            end
            OP_MSUM:
            begin
                prod_reg <= {ph_reg, 32'd0} + PROD_W'(pl_reg);
            end
            OP_IP:
            begin
                ip_reg <= (ip_over || ip_sum[62]) ? {IP_W{1'b1}} : ip_sum[IP_W-1:0];
            end
            OP_LAMBDA:
            begin
                lambda_reg <= lam_val;
                x_reg      <= 64'(lam_val);
                p_reg      <= 6'd63;
            end
            OP_LN_NORM:
            begin
                if (x_reg[63:56] == '0)
                begin
                    x_reg <= x_reg << 8;
                    p_reg <= p_reg - 6'd8;
                end
                else
                begin
                    x_reg <= x_reg << 1;
                    p_reg <= p_reg - 6'd1;
                end
            end
            OP_LN_SQINIT:
            begin
                m_reg   <= x_reg[63:33];
                fb_reg  <= '0;
                cnt_reg <= '0;
            end
            OP_LN_SQ:
            begin
                // one log2 fraction bit per squaring
                if (sq_top[31])
                begin
                    m_reg  <= sq_top[31:1];
                    fb_reg <= {fb_reg[LOG_BITS-2:0], 1'b1};
                end
                else
                begin
                    m_reg  <= sq_top[30:0];
                    fb_reg <= {fb_reg[LOG_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
            end
            OP_LN_MAG:
            begin
                neg_reg <= y_val[31];
                mag_reg <= y_val[31] ? 31'(-y_val) : 31'(y_val);
            end
            OP_LN_MUL:
            begin
                lprod_reg <= {32'd0, mag_reg} * {31'd0, LN2_Q32};
            end
            OP_LN_RND:
            begin
                res_reg <= RW'(rnd_val >> (56 - FRAC_BITS));
            end
            OP_TMUL:
            begin
                tp_reg <= TPW'(fm) * TPW'(res_reg);
            end
            OP_TSUB1:
            begin
                t1_reg <= (neg_reg ? -tp_ext : tp_ext) - $signed(64'(lf_rd_reg));
            end
            OP_TSUB2:
            begin
                term_reg     <= lam_zero ? S40_MIN[SCORE_W-1:0] : sat40(t2_val);
                term_err_reg <= lam_zero;
            end
            OP_ACC:
            begin
                score_word_reg.passage_score <= acc_sum;
                score_word_reg.domain_error  <= err_reg | term_err_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_reg          <= MU_RESET;
            n_reg           <= N_RESET;
            accum_reg       <= '0;
            err_reg         <= 1'b0;
            score_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_SMOOTHING_MU:    mu_reg <= cfg_data[15:0];
                    CFG_COLLECTION_SIZE: n_reg  <= cfg_data[N_W-1:0];
                endcase
            end
            if (score_valid_reg && !score_stall)
            begin
                score_valid_reg <= 1'b0;
            end
            if (cmd.op == OP_ACC)
            begin
                if (last_reg)
                begin
                    score_valid_reg <= 1'b1;
                    accum_reg       <= '0;
                    err_reg         <= 1'b0;
                end
                else
                begin
                    accum_reg <= acc_sum;
                    err_reg   <= err_reg | term_err_reg;
                end
            end
        end
    end

    assign score_word  = score_word_reg;
    assign score_valid = score_valid_reg;

    always_comb
    begin
        status.div_busy  = div_busy;
        status.norm_done = x_reg[63];
        status.sq_last   = cnt_reg == 5'(LOG_BITS - 1);
        status.lam_zero  = lam_zero;
        status.fill_last = k_reg == IW'(MAX_TERM_FREQ);
        status.out_free  = !score_valid_reg || !score_stall;
    end

endmodule
`default_nettype wire

FILE: rtl/ppts_ctrl.sv
// Controller: sequences the table fill after reset and each term through the datapath.
`default_nettype none
module ppts_ctrl
    import ppts_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       term_valid,
    output logic            term_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [4:0] {
        S_FILL_START,
        S_FILL_LOAD,
        S_IDLE,
        S_MUL1,
        S_MSUM1,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_IP,
        S_MUL2,
        S_MSUM2,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_LAMBDA,
        S_NORM,
        S_SQ,
        S_MAG,
        S_LNMUL,
        S_LNRND,
        S_FSTORE,
        S_TMUL,
        S_TSUB1,
        S_TSUB2,
        S_ACC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;
    logic   fill_reg;
    logic   fill_next;

    always_comb
    begin
        state_next = state_reg;
        stall_next = stall_reg;
        fill_next  = fill_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_FILL_START:
            begin
                cmd.op     = OP_FILL_START;
                state_next = S_FILL_LOAD;
            end
            S_FILL_LOAD:
            begin
                cmd.op     = OP_FILL_LOAD;
                state_next = S_NORM;
            end
            S_IDLE:
            begin
                if (term_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_MUL1;
                    stall_next = 1'b1;
                end
            end
            S_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = S_MSUM1;
            end
            S_MSUM1:
            begin
                cmd.op     = OP_MSUM;
                state_next = S_DIV1_GO;
            end
            S_DIV1_GO:
            begin
                cmd.op     = OP_DIV1;
                state_next = S_DIV1_WAIT;
            end
            S_DIV1_WAIT:
            begin
                if (!status.div_busy)
                    state_next = S_IP;
            end
            S_IP:
            begin
                cmd.op     = OP_IP;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = S_MSUM2;
            end
            S_MSUM2:
            begin
                cmd.op     = OP_MSUM;
                state_next = S_DIV2_GO;
            end
            S_DIV2_GO:
            begin
                cmd.op     = OP_DIV2;
                state_next = S_DIV2_WAIT;
            end
            S_DIV2_WAIT:
            begin
                if (!status.div_busy)
                    state_next = S_LAMBDA;
            end
            S_LAMBDA:
            begin
                cmd.op     = OP_LAMBDA;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                // zero rate skips the log entirely
                priority if (!fill_reg && status.lam_zero)
                    state_next = S_TSUB2;
                else if (status.norm_done)
                begin
                    cmd.op     = OP_LN_SQINIT;
                    state_next = S_SQ;
                end
                else
                    cmd.op = OP_LN_NORM;
            end
            S_SQ:
            begin
                cmd.op = OP_LN_SQ;
                if (status.sq_last)
                    state_next = S_MAG;
            end
            S_MAG:
            begin
                cmd.op     = OP_LN_MAG;
                state_next = S_LNMUL;
            end
            S_LNMUL:
            begin
                cmd.op     = OP_LN_MUL;
                state_next = S_LNRND;
            end
            S_LNRND:
            begin
                cmd.op     = OP_LN_RND;
                state_next = fill_reg ? S_FSTORE : S_TMUL;
            end
            S_FSTORE:
            begin
                cmd.op = OP_FILL_STORE;
                if (status.fill_last)
                begin
                    state_next = S_IDLE;
                    stall_next = 1'b0;
                    fill_next  = 1'b0;
                end
                else
                    state_next = S_FILL_LOAD;
            end
            S_TMUL:
            begin
                cmd.op     = OP_TMUL;
                state_next = S_TSUB1;
            end
            S_TSUB1:
            begin
                cmd.op     = OP_TSUB1;
                state_next = S_TSUB2;
            end
            S_TSUB2:
            begin
                cmd.op     = OP_TSUB2;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // hold until the output register can take a word
                if (status.out_free)
                begin
                    cmd.op     = OP_ACC;
                    state_next = S_IDLE;
                    stall_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                stall_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL_START;
            stall_reg <= 1'b1;
            fill_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
            fill_reg  <= fill_next;
        end
    end

    assign term_stall = stall_reg;

endmodule
`default_nettype wire

FILE: rtl/poisson_passage_term_scorer.sv
// Top level of the poisson passage term scorer: controller, datapath and checks.
// Each term takes two passes of the one-bit-per-cycle shared divider, DIVW bits each,
// DIVW = max(56 + FRAC_BITS, 78); a stalled score word holds the next term off.
// The score word appears only after the last term is accepted.
// After reset the log-factorial memory is filled over MAX_TERM_FREQ + 1 entries, with
// term_stall high; configuration writes are taken throughout.
`default_nettype none
`include "poisson_passage_term_scorer_defines.svh"
module poisson_passage_term_scorer
    import ppts_pkg::*;
#(
    parameter int MAX_TERM_FREQ = 1023,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             term_valid,
    output logic                  term_stall,
    input  wire term_word_t       term_word,
    output logic                  score_valid,
    input  wire logic             score_stall,
    output score_word_t           score_word,
    input  wire logic             cfg_wr_en,
    input  wire cfg_index_t       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ppts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .term_valid (term_valid),
        .term_stall (term_stall),
        .status     (status),
        .cmd        (cmd)
    );

    ppts_datapath #(
        .MAX_TERM_FREQ (MAX_TERM_FREQ),
        .FRAC_BITS     (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .term_word   (term_word),
        .score_word  (score_word),
        .score_valid (score_valid),
        .score_stall (score_stall),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    `PPTS_ASSERT_IMP(a_capture_on_accept, clk, rst_n, (term_valid && !term_stall), (cmd.op == OP_CAPTURE))
    `PPTS_ASSERT_IMP(a_capture_only_accept, clk, rst_n, (cmd.op == OP_CAPTURE), (term_valid && !term_stall))
    `PPTS_ASSERT_NXT(a_busy_after_accept, clk, rst_n, (term_valid && !term_stall), term_stall)
    `PPTS_ASSERT_IMP(a_acc_needs_room, clk, rst_n, (cmd.op == OP_ACC), status.out_free)

endmodule
`default_nettype wire
